>>> src/spbpm_pkg.sv
// Shared types and constants for the spectrum band peak meter.
package spbpm_pkg;

    localparam logic [1:0] OP_BIN  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [2:0] CFG_BAND_COUNT   = 3'd0;
    localparam logic [2:0] CFG_FLOOR_DB     = 3'd1;
    localparam logic [2:0] CFG_NORM_GAIN    = 3'd2;
    localparam logic [2:0] CFG_ATTACK_COEF  = 3'd3;
    localparam logic [2:0] CFG_RELEASE_COEF = 3'd4;
    localparam logic [2:0] CFG_HOLD_TIME    = 3'd5;
    localparam logic [2:0] CFG_FALL_PER_MS  = 3'd6;

    localparam logic [6:0]         RST_BAND_COUNT   = 7'd64;
    localparam logic signed [15:0] RST_FLOOR_DB     = -16'sd20480;
    localparam logic [25:0]        RST_NORM_GAIN    = 26'd53687091;
    localparam logic [16:0]        RST_ATTACK_COEF  = 17'd32768;
    localparam logic [16:0]        RST_RELEASE_COEF = 17'd6554;
    localparam logic [15:0]        RST_HOLD_TIME    = 16'd1000;
    localparam logic [23:0]        RST_FALL_PER_MS  = 24'd4194;

    localparam logic [23:0] LEVEL_MAX = 24'hFFFFFF;
    localparam int CMDQ_DEPTH = 4;

    typedef enum logic [1:0] {
        CMD_FINISH,
        CMD_TICK,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [5:0]         band;
        logic               oor;
        logic signed [15:0] xmax;
        logic [15:0]        elapsed;
    } cmd_t;

    typedef struct packed {
        logic [6:0]         band_count;
        logic signed [15:0] floor_db;
        logic [25:0]        norm_gain;
        logic [16:0]        attack_coef;
        logic [16:0]        release_coef;
        logic [15:0]        hold_time_ms;
        logic [23:0]        fall_per_ms;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LATCH,
        S_WRITE,
        S_RESULT
    } back_state_t;

endpackage

>>> src/spbpm_cmd_fifo.sv
// Short command queue between the front and back parts.
module spbpm_cmd_fifo
    import spbpm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output cmd_t dout,
    output logic empty
);

    localparam int PW = $clog2(CMDQ_DEPTH);

    cmd_t          slot_reg [CMDQ_DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [PW:0]   cnt_reg;

    assign full  = (cnt_reg == (PW+1)'(CMDQ_DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
        end
    end

endmodule

>>> src/spbpm_front.sv
// Front part: accepts items, tracks the running maximum and queues commands.
module spbpm_front
    import spbpm_pkg::*;
#(
    parameter int BANDS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         opcode,
    input  logic [5:0]         band_index,
    input  logic signed [15:0] bin_db,
    input  logic               last_bin,
    input  logic [15:0]        elapsed_ms,
    input  cfg_t               cfg,
    input  logic               q_full,
    output logic               q_push,
    output cmd_t               q_data
);

    logic signed [15:0] rmax_reg;
    logic signed [15:0] rmax_next;
    logic signed [15:0] new_max;
    logic               accept;
    logic               in_range;

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign new_max  = (bin_db > rmax_reg) ? bin_db : rmax_reg;
    assign in_range = ({1'b0, band_index} < cfg.band_count) && (BANDS > int'(band_index));

    always_comb
    begin
        rmax_next      = rmax_reg;
        q_push         = 1'b0;
        q_data.kind    = CMD_READ;
        q_data.band    = band_index;
        q_data.oor     = !(BANDS > int'(band_index));
        q_data.xmax    = new_max;
        q_data.elapsed = elapsed_ms;
        case (opcode)
            OP_BIN:
            begin
                q_data.kind = CMD_FINISH;
                if (accept)
                begin
                    rmax_next = last_bin ? cfg.floor_db : new_max;
                    q_push    = last_bin && in_range;
                end
            end
            OP_TICK:
            begin
                q_data.kind = CMD_TICK;
                q_push      = accept && (elapsed_ms != '0);
            end
            OP_READ:
            begin
                q_push = accept;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmax_reg <= RST_FLOOR_DB;
        end
        else
        begin
            rmax_reg <= rmax_next;
        end
    end

endmodule

>>> src/spbpm_back.sv
// Back part: per-band level, peak and hold updates over the band memory.
module spbpm_back
    import spbpm_pkg::*;
#(
    parameter int BANDS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_empty,
    input  cmd_t        q_dout,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  out_band,
    output logic [23:0] band_level,
    output logic [23:0] band_peak
);

    localparam int DEPTH = (BANDS < 64) ? BANDS : 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [6:0]  n_walk;

    logic [63:0] mem [DEPTH];
    logic        vld_reg [DEPTH];
    logic [63:0] mem_q;
    logic        vld_q;
    logic [AW-1:0] addr;
    logic        mem_we;
    logic [63:0] wdata;

    logic [42:0]        prod_t_reg;
    logic [39:0]        prod_f_reg;
    logic signed [42:0] prod_s_reg;
    logic [23:0]        lvl_reg, pk_reg;
    logic [15:0]        hold_reg;

    logic               res_valid_reg, res_valid_next, res_load;
    logic [5:0]         res_band_reg;
    logic [23:0]        res_level_reg, res_peak_reg;

    logic signed [15:0] xc;
    logic signed [16:0] diff_s;
    logic [16:0]        diff_u;
    logic [63:0]        entry;
    logic [23:0]        cur;
    logic [23:0]        tgt;
    logic signed [24:0] dif;
    logic signed [17:0] coef_s;
    logic signed [26:0] step;
    logic signed [27:0] nl;
    logic [23:0]        lvl_new, pk_new;
    logic [15:0]        hold_new;
    logic signed [40:0] pf;

    assign n_walk = (cfg.band_count < 7'(DEPTH)) ? cfg.band_count : 7'(DEPTH);
    assign addr   = (cmd_reg.kind == CMD_TICK) ? cnt_reg[AW-1:0] : cmd_reg.band[AW-1:0];
    assign entry  = (vld_q && !cmd_reg.oor) ? mem_q : '0;
    assign cur    = entry[63:40];

    always_comb
    begin
        xc = (cmd_reg.xmax < cfg.floor_db) ? cfg.floor_db : cmd_reg.xmax;
        if (xc > 16'sd0)
        begin
            xc = 16'sd0;
        end
        diff_s = 17'(xc) - 17'(cfg.floor_db);
        diff_u = (diff_s < 17'sd0) ? '0 : diff_s;
        tgt    = (|prod_t_reg[42:40]) ? LEVEL_MAX : prod_t_reg[39:16];
        dif    = $signed({1'b0, tgt}) - $signed({1'b0, cur});
        coef_s = $signed({1'b0, (tgt > cur) ? cfg.attack_coef : cfg.release_coef});
    end

    always_comb
    begin
        step     = prod_s_reg[42:16];
        nl       = $signed({4'b0, lvl_reg}) + 28'(step);
        lvl_new  = lvl_reg;
        pk_new   = pk_reg;
        hold_new = hold_reg;
        pf       = $signed({17'b0, pk_reg}) - $signed({1'b0, prod_f_reg});
        if (cmd_reg.kind == CMD_FINISH)
        begin
            if (nl < 28'sd0)
            begin
                lvl_new = '0;
            end
            else if (nl > $signed({4'b0, LEVEL_MAX}))
            begin
                lvl_new = LEVEL_MAX;
            end
            else
            begin
                lvl_new = nl[23:0];
            end
            if (lvl_new >= pk_reg)
            begin
                pk_new   = lvl_new;
                hold_new = cfg.hold_time_ms;
            end
        end
        else if (hold_reg != '0)
        begin
            hold_new = (hold_reg > cmd_reg.elapsed) ? hold_reg - cmd_reg.elapsed : '0;
        end
        else
        begin
            pk_new = (pf < $signed({17'b0, lvl_reg})) ? lvl_reg : pf[23:0];
        end
        wdata = {lvl_new, pk_new, hold_new};
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        res_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_dout;
                    cnt_next = '0;
                    if (q_dout.kind == CMD_TICK && n_walk == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_LATCH;
            end
            S_LATCH:
            begin
                state_next = (cmd_reg.kind == CMD_READ) ? S_RESULT : S_WRITE;
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
                if (cmd_reg.kind == CMD_TICK)
                begin
                    cnt_next   = cnt_reg + 7'd1;
                    state_next = (cnt_reg + 7'd1 == n_walk) ? S_IDLE : S_READ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESULT:
            begin
                if (!res_valid_reg || pop)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        res_valid_next = (res_valid_reg && !pop) || res_load;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr] <= wdata;
        end
        mem_q      <= mem[addr];
        vld_q      <= vld_reg[addr];
        prod_t_reg <= diff_u * cfg.norm_gain;
        prod_f_reg <= cfg.fall_per_ms * cmd_reg.elapsed;
        if (state_reg == S_LATCH)
        begin
            lvl_reg    <= cur;
            pk_reg     <= entry[39:16];
            hold_reg   <= entry[15:0];
            prod_s_reg <= dif * coef_s;
        end
        if (res_load)
        begin
            res_band_reg  <= cmd_reg.band;
            res_level_reg <= cur;
            res_peak_reg  <= entry[39:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (mem_we)
        begin
            vld_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign empty      = !res_valid_reg;
    assign out_band   = res_band_reg;
    assign band_level = res_level_reg;
    assign band_peak  = res_peak_reg;

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && cmd_reg.kind == CMD_TICK) |-> cnt_reg < n_walk)
        else $error("tick walk passed the band count");

    a_latch_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LATCH) |-> ($past(state_reg) == S_READ))
        else $error("memory data used without a read cycle");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && !res_valid_reg) |=> (res_valid_reg && state_reg == S_IDLE))
        else $error("read result was not delivered");

endmodule

>>> src/spectrum_band_peak_meter_top.sv
// Top level of the spectrum band peak meter with its configuration registers.
//
//   Channel   Direction  Transfer condition   Signals
//   input     in         push && !full        opcode band_index bin_db last_bin elapsed_ms
//   result    out        pop && !empty        out_band band_level band_peak
//   config    in         cfg_we               cfg_index cfg_data
//
// Bins that are not last are not queued, but like every item they wait while full is high.
// The back part works over the single band memory port: a finishing bin takes the read,
// latch and write states, a tick repeats them per band, and a read ends in S_RESULT.
// A four-entry command queue lets the input run ahead of the back part.
// Reset clears all band state at once; there is no clearing pass.
module spectrum_band_peak_meter_top
    import spbpm_pkg::*;
#(
    parameter int BANDS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         opcode,
    input  logic [5:0]         band_index,
    input  logic signed [15:0] bin_db,
    input  logic               last_bin,
    input  logic [15:0]        elapsed_ms,
    output logic               empty,
    input  logic               pop,
    output logic [5:0]         out_band,
    output logic [23:0]        band_level,
    output logic [23:0]        band_peak,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [25:0]        cfg_data
);

    cfg_t cfg_reg;
    logic q_full, q_push, q_empty, q_pop;
    cmd_t q_din, q_dout;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_count   <= RST_BAND_COUNT;
            cfg_reg.floor_db     <= RST_FLOOR_DB;
            cfg_reg.norm_gain    <= RST_NORM_GAIN;
            cfg_reg.attack_coef  <= RST_ATTACK_COEF;
            cfg_reg.release_coef <= RST_RELEASE_COEF;
            cfg_reg.hold_time_ms <= RST_HOLD_TIME;
            cfg_reg.fall_per_ms  <= RST_FALL_PER_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BAND_COUNT:   cfg_reg.band_count   <= cfg_data[6:0];
                CFG_FLOOR_DB:     cfg_reg.floor_db     <= $signed(cfg_data[15:0]);
                CFG_NORM_GAIN:    cfg_reg.norm_gain    <= cfg_data;
                CFG_ATTACK_COEF:  cfg_reg.attack_coef  <= cfg_data[16:0];
                CFG_RELEASE_COEF: cfg_reg.release_coef <= cfg_data[16:0];
                CFG_HOLD_TIME:    cfg_reg.hold_time_ms <= cfg_data[15:0];
                CFG_FALL_PER_MS:  cfg_reg.fall_per_ms  <= cfg_data[23:0];
                default:          cfg_reg.band_count   <= cfg_reg.band_count;
            endcase
        end
    end

    spbpm_front #(.BANDS(BANDS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .band_index (band_index),
        .bin_db     (bin_db),
        .last_bin   (last_bin),
        .elapsed_ms (elapsed_ms),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_din)
    );

    spbpm_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    spbpm_back #(.BANDS(BANDS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_dout     (q_dout),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .out_band   (out_band),
        .band_level (band_level),
        .band_peak  (band_peak)
    );

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the spectrum band peak meter top level.
`timescale 1ns / 1ps

module tb_top;
    import spbpm_pkg::*;

    localparam int NBANDS = 64;
    localparam int STALL_LIMIT = 200000;
    localparam int N_RANDOM = 1630;

    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         band;
        logic signed [15:0] db;
        logic               last;
        logic [15:0]        ms;
    } meter_item_t;

    typedef struct packed {
        logic [5:0]  band;
        logic [23:0] level;
        logic [23:0] peak;
    } band_report_t;

    typedef struct {
        meter_item_t item;
        logic        has_known;
        logic [23:0] known_level;
        logic [23:0] known_peak;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [1:0]         opcode;
    logic [5:0]         band_index;
    logic signed [15:0] bin_db;
    logic               last_bin;
    logic [15:0]        elapsed_ms;
    logic               empty;
    logic               pop;
    logic [5:0]         out_band;
    logic [23:0]        band_level;
    logic [23:0]        band_peak;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [25:0]        cfg_data;

    spectrum_band_peak_meter_top dut (.*);

    logic [6:0]         m_band_count;
    logic signed [15:0] m_floor;
    logic [25:0]        m_gain;
    logic [16:0]        m_attack;
    logic [16:0]        m_release;
    logic [15:0]        m_hold_time;
    logic [23:0]        m_fall;
    logic [23:0]        level_mem [NBANDS];
    logic [23:0]        peak_mem [NBANDS];
    logic [15:0]        hold_mem [NBANDS];
    logic signed [15:0] bin_max;

    band_report_t expected_reports [$];
    int  errors = 0;
    int  idle_cycles = 0;
    int  n_reads_seen = 0;
    int  n_ticks = 0;
    int  n_finishes = 0;
    bit  hold_off_reader = 0;
    bit  stim_done = 0;

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic longint sat_level(longint v);
        if (v < 0) return 0;
        if (v > 64'd16777215) return 16777215;
        return v;
    endfunction

    function automatic longint floor_shift16(longint p);
        if (p >= 0) return p >>> 16;
        return -((-p + 65535) >>> 16);
    endfunction

    task automatic close_band(input int b);
        longint x, diff, target, cur, step;
        logic [16:0] coef;
        x = bin_max;
        if (x < m_floor) x = m_floor;
        if (x > 0) x = 0;
        diff = x - longint'(m_floor);
        if (diff < 0) diff = 0;
        target = sat_level((diff * longint'(m_gain)) >>> 16);
        cur = level_mem[b];
        coef = (target > cur) ? m_attack : m_release;
        step = floor_shift16((target - cur) * longint'(coef));
        cur = sat_level(cur + step);
        level_mem[b] = cur[23:0];
        if (cur[23:0] >= peak_mem[b])
        begin
            peak_mem[b] = cur[23:0];
            hold_mem[b] = m_hold_time;
        end
    endtask

    task automatic advance_time(input logic [15:0] ms);
        int n;
        longint p;
        n = (m_band_count < NBANDS) ? m_band_count : NBANDS;
        for (int b = 0; b < n; b++)
        begin
            if (hold_mem[b] > 0)
                hold_mem[b] = (hold_mem[b] > ms) ? hold_mem[b] - ms : 16'd0;
            else
            begin
                p = longint'(peak_mem[b]) - longint'(m_fall) * longint'(ms);
                if (p < longint'(level_mem[b])) p = longint'(level_mem[b]);
                peak_mem[b] = 24'(sat_level(p));
            end
        end
    endtask

    task automatic predict_meter(input meter_item_t it);
        band_report_t r;
        case (it.op)
            OP_BIN:
            begin
                if (it.db > bin_max) bin_max = it.db;
                if (it.last)
                begin
                    if (it.band < m_band_count) close_band(it.band);
                    bin_max = m_floor;
                    n_finishes++;
                end
            end
            OP_TICK:
            begin
                if (it.ms != 0) advance_time(it.ms);
                n_ticks++;
            end
            OP_READ:
            begin
                r.band = it.band;
                r.level = level_mem[it.band];
                r.peak = peak_mem[it.band];
                expected_reports.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [25:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BAND_COUNT:   m_band_count = val[6:0];
            CFG_FLOOR_DB:     m_floor = val[15:0];
            CFG_NORM_GAIN:    m_gain = val;
            CFG_ATTACK_COEF:  m_attack = val[16:0];
            CFG_RELEASE_COEF: m_release = val[16:0];
            CFG_HOLD_TIME:    m_hold_time = val[15:0];
            CFG_FALL_PER_MS:  m_fall = val[23:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (4 * NBANDS * 4 + 40) @(posedge clk);
    endtask

    task automatic send_item(input meter_item_t it, input bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        opcode <= it.op;
        band_index <= it.band;
        bin_db <= it.db;
        last_bin <= it.last;
        elapsed_ms <= it.ms;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_meter(it);
    endtask

    function automatic meter_item_t make_item(input logic [1:0] op, input int band,
                                              input int db, input bit last, input int ms);
        meter_item_t it;
        it.op = op;
        it.band = 6'(band);
        it.db = 16'(db);
        it.last = last;
        it.ms = 16'(ms);
        return it;
    endfunction

    function automatic meter_item_t random_item();
        meter_item_t it;
        int r;
        r = $urandom_range(0, 99);
        it.band = 6'($urandom_range(0, 63));
        it.db = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'(-$urandom_range(0, 16000));
        it.last = $urandom_range(0, 2) == 0;
        it.ms = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 300));
        if (r < 70) it.op = OP_BIN;
        else if (r < 76) it.op = OP_TICK;
        else if (r < 98) it.op = OP_READ;
        else it.op = 2'd3;
        return it;
    endfunction

    // Known-answer rows first, then rows checked by the predictor.
    stim_row_t directed [$];

    task automatic build_directed();
        stim_row_t s;
        s.has_known = 1;
        s.known_level = 0;
        s.known_peak = 0;
        s.item = make_item(OP_READ, 0, 0, 0, 0);     directed.push_back(s);
        s.item = make_item(OP_READ, 63, -1, 1, 65535); directed.push_back(s);
        s.has_known = 0;
        s.item = make_item(OP_BIN, 5, 32767, 0, 0);   directed.push_back(s);
        s.item = make_item(OP_BIN, 5, -32768, 1, 0);  directed.push_back(s);
        s.item = make_item(OP_READ, 5, 0, 0, 0);      directed.push_back(s);
        s.item = make_item(OP_BIN, 63, -32768, 1, 0); directed.push_back(s);
        s.item = make_item(OP_READ, 63, 0, 0, 0);     directed.push_back(s);
        s.item = make_item(OP_TICK, 0, 0, 0, 0);      directed.push_back(s);
        s.item = make_item(OP_TICK, 0, 0, 0, 400);    directed.push_back(s);
        s.item = make_item(OP_TICK, 0, 0, 0, 65535);  directed.push_back(s);
        s.item = make_item(OP_TICK, 0, 0, 0, 65535);  directed.push_back(s);
        s.item = make_item(OP_READ, 5, 0, 0, 0);      directed.push_back(s);
        s.item = make_item(2'd3, 7, 100, 1, 9);       directed.push_back(s);
        s.item = make_item(OP_BIN, 9, -3000, 0, 0);   directed.push_back(s);
        s.item = make_item(OP_BIN, 9, -5000, 1, 0);   directed.push_back(s);
        s.item = make_item(OP_BIN, 9, -20000, 1, 0);  directed.push_back(s);
        s.item = make_item(OP_READ, 9, 0, 0, 0);      directed.push_back(s);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result side: checks each transfer and stalls at random.
    always @(posedge clk)
    begin
        band_report_t w;
        if (rst_n && pop && !empty)
        begin
            n_reads_seen++;
            if (expected_reports.size() == 0)
            begin
                $display("tb: unexpected result for band %0d at %0t", out_band, $time);
                errors++;
            end
            else
            begin
                w = expected_reports.pop_front();
                if (out_band !== w.band) report_mismatch("out_band", out_band, w.band);
                if (band_level !== w.level) report_mismatch("band_level", band_level, w.level);
                if (band_peak !== w.peak) report_mismatch("band_peak", band_peak, w.peak);
            end
        end
        if (hold_off_reader) pop <= 1'b0;
        else if ($urandom_range(0, 3) == 0)
            pop <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
        else pop <= 1'b1;
    end

    initial
    begin
        stim_row_t s;
        int long_hold;
        push = 0; opcode = 0; band_index = 0; bin_db = 0; last_bin = 0; elapsed_ms = 0;
        pop = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
        m_band_count = RST_BAND_COUNT; m_floor = RST_FLOOR_DB; m_gain = RST_NORM_GAIN;
        m_attack = RST_ATTACK_COEF; m_release = RST_RELEASE_COEF;
        m_hold_time = RST_HOLD_TIME; m_fall = RST_FALL_PER_MS;
        for (int b = 0; b < NBANDS; b++)
        begin
            level_mem[b] = 0; peak_mem[b] = 0; hold_mem[b] = 0;
        end
        bin_max = m_floor;
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        build_directed();
        foreach (directed[i])
        begin
            s = directed[i];
            send_item(s.item, 0);
            if (s.has_known)
            begin
                expected_reports[$].level = s.known_level;
                expected_reports[$].peak = s.known_peak;
            end
        end
        push <= 0;
        wait_idle();

        // Four register settings, including both extremes of the gain, hold and fall registers.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_BAND_COUNT, 64); write_reg(CFG_FLOOR_DB, 26'h8000);
                    write_reg(CFG_NORM_GAIN, 26'h3FFFFFF); write_reg(CFG_ATTACK_COEF, 65536);
                    write_reg(CFG_RELEASE_COEF, 65536); write_reg(CFG_HOLD_TIME, 0);
                    write_reg(CFG_FALL_PER_MS, 24'hFFFFFF);
                end
                1:
                begin
                    write_reg(CFG_BAND_COUNT, 1); write_reg(CFG_FLOOR_DB, 26'hFFFF);
                    write_reg(CFG_NORM_GAIN, 0); write_reg(CFG_ATTACK_COEF, 0);
                    write_reg(CFG_RELEASE_COEF, 0); write_reg(CFG_HOLD_TIME, 65535);
                    write_reg(CFG_FALL_PER_MS, 0);
                end
                2:
                begin
                    write_reg(CFG_BAND_COUNT, 0); write_reg(CFG_FLOOR_DB, 26'h0100);
                    write_reg(CFG_NORM_GAIN, RST_NORM_GAIN);
                    write_reg(CFG_ATTACK_COEF, RST_ATTACK_COEF);
                end
                default:
                begin
                    write_reg(CFG_BAND_COUNT, $urandom_range(20, 127));
                    write_reg(CFG_FLOOR_DB, 26'(16'($urandom_range(32768, 65535))));
                    write_reg(CFG_NORM_GAIN, $urandom_range(1000000, 67108863));
                    write_reg(CFG_ATTACK_COEF, $urandom_range(0, 65536));
                    write_reg(CFG_RELEASE_COEF, $urandom_range(0, 65536));
                    write_reg(CFG_HOLD_TIME, $urandom_range(0, 2000));
                    write_reg(CFG_FALL_PER_MS, $urandom_range(0, 200000));
                end
            endcase
            for (int k = 0; k < N_RANDOM / 4; k++)
            begin
                if (phase == 1 && k == 100)
                begin
                    long_hold = $urandom_range(150, 300);
                    fork
                        begin
                            hold_off_reader = 1;
                            repeat (long_hold) @(posedge clk);
                            hold_off_reader = 0;
                        end
                    join_none
                end
                if (phase == 2 && k == 200)
                begin
                    push <= 0;
                    while (expected_reports.size() != 0) @(posedge clk);
                end
                send_item(random_item(), k % 150 > 20);
            end
            push <= 0;
            wait_idle();
        end
        stim_done = 1;
        $display("tb: %0d reads checked, %0d ticks and %0d band closes over four settings",
                 n_reads_seen, n_ticks, n_finishes);
        if (errors == 0 && expected_reports.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> filelist.f
src/spbpm_pkg.sv
src/spbpm_cmd_fifo.sv
src/spbpm_front.sv
src/spbpm_back.sv
src/spectrum_band_peak_meter_top.sv
bench/tb_top.sv
